@@ sv/efsd_pkg.sv @@
// Package for the frame sync deframer: widths, sync constants and the
// sample record handed from the byte parser to the scaling stage.
// No dependencies.
`default_nettype none

package efsd_pkg;

    localparam int CHANNELS   = 8;
    localparam int CHAN_POS_W = $clog2(CHANNELS + 1);
    localparam int CHAN_IDX_W = 3;
    localparam int RAW_W      = 24;
    localparam int SCALE_W    = 32;
    localparam int UV_W       = 48;
    localparam int PROD_W     = RAW_W + SCALE_W + 1;
    localparam int FRAC_DROP  = 8;
    localparam int OUT_DATA_W = 80;

    localparam logic [7:0]        SYNC_BYTE   = 8'd192;
    localparam logic [7:0]        ZERO_BYTE   = 8'd0;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'd450000;

    typedef struct packed {
        logic signed [RAW_W-1:0]      raw;
        logic        [CHAN_IDX_W-1:0] chan;
        logic                         last;
    } t_sample;

endpackage

`default_nettype wire

@@ sv/eeg_frame_sync_deframer_core.sv @@
// Frame sync deframer top level: streaming ports, scale register, parser and scaler.
// Depends on efsd_pkg, efsd_parser and efsd_scale.
//
// Usage:
//   The slave stream takes one received byte per item on i_s_tdata. The parser
//   hunts for the sync pattern 192, 0, 0, then gathers CHANNELS big-endian
//   3-byte samples. A wrong second or third sync byte holds the parser in that
//   sync state until a zero byte arrives.
//   Every third data byte yields one item on the master stream: raw sample,
//   scaled microvolts (Q.16), channel index, and tlast on the frame's final
//   channel. After the final channel the parser returns to the hunt.
//   A result item loads into the sample register at the edge that accepts its
//   last byte; the multiply result lands in the output register when it is free.
//   Throughput: one byte per cycle while the sample register is empty or can
//   advance, with each byte handled combinationally by the parser and the one
//   24x33 multiply between the sample and output registers.
//   Stall: when the receiver drops i_m_tready the output register and sample
//   register hold; bytes are still taken until the sample register is full.
//   Reset (synchronous, active low) returns to the hunt, empties both stages
//   and loads the scale register with 450000.
//   The scale register is written through the cfg channel, always ready;
//   write it only while no item is in flight.
`default_nettype none

module eeg_frame_sync_deframer_core
    import efsd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // config write channel: scale_factor, unsigned Q8.24
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [SCALE_W-1:0]    i_cfg_data,
    // slave stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [7:0]            i_s_tdata,   // [7:0] data_byte
    // master stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0]      o_m_tdata,   // [23:0] raw_sample,
                                                    // [71:24] microvolts_q16,
                                                    // [74:72] channel_index, zero above
    output logic                       o_m_tlast    // final_channel
);

    logic [SCALE_W-1:0]    r_scale;
    logic                  accept;
    logic                  s1_valid;
    t_sample               s1_sample;
    logic                  out_valid;
    logic                  out_free;
    logic                  advance;
    logic signed [RAW_W-1:0] raw;
    logic signed [UV_W-1:0]  uv;
    logic [CHAN_IDX_W-1:0] chan;
    logic                  last;

    // scale register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= SCALE_RESET;
        end else if (i_cfg_valid) begin
            r_scale <= i_cfg_data;
        end
    end

    // pipeline flow: output register frees when empty or taken,
    // sample register advances into it when free
    assign out_free   = !out_valid || i_m_tready;
    assign advance    = s1_valid && out_free;
    assign o_s_tready = !s1_valid || out_free;
    assign accept     = i_s_tvalid && o_s_tready;

    efsd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_byte    (i_s_tdata),
        .i_advance (advance),
        .o_valid   (s1_valid),
        .o_sample  (s1_sample)
    );

    efsd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (advance),
        .i_sample    (s1_sample),
        .i_scale     (r_scale),
        .i_out_ready (i_m_tready),
        .o_valid     (out_valid),
        .o_raw       (raw),
        .o_uv        (uv),
        .o_chan      (chan),
        .o_last      (last)
    );

    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {{(OUT_DATA_W - CHAN_IDX_W - UV_W - RAW_W){1'b0}}, chan, uv, raw};
    assign o_m_tlast  = last;

endmodule

`default_nettype wire

@@ sv/efsd_parser.sv @@
// Byte parser: sync hunt, big-endian 3-byte gathering and the sample register.
// Depends on efsd_pkg.
`default_nettype none

module efsd_parser
    import efsd_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_accept,
    input  wire logic [7:0] i_byte,
    input  wire logic       i_advance,
    output logic            o_valid,
    output t_sample         o_sample
);

    typedef enum logic [1:0] {
        ST_HUNT  = 2'd0,
        ST_SYNC2 = 2'd1,
        ST_SYNC3 = 2'd2,
        ST_DATA  = 2'd3
    } t_state;

    t_state                r_state, n_state;
    logic [1:0]            r_byte_pos, n_byte_pos;
    logic [CHAN_POS_W-1:0] r_chan_pos, n_chan_pos;
    logic [15:0]           r_held, n_held;
    logic                  emit;
    t_sample               smp;
    logic                  r_valid;
    t_sample               r_sample;

    always_comb begin
        n_state    = r_state;
        n_byte_pos = r_byte_pos;
        n_chan_pos = r_chan_pos;
        n_held     = r_held;
        emit       = 1'b0;
        smp.raw    = $signed({r_held, i_byte});
        smp.chan   = r_chan_pos[CHAN_IDX_W-1:0];
        smp.last   = (r_chan_pos == CHAN_POS_W'(CHANNELS - 1));
        case (r_state)
            ST_HUNT: begin
                if (i_byte == SYNC_BYTE) n_state = ST_SYNC2;
            end
            ST_SYNC2: begin
                if (i_byte == ZERO_BYTE) n_state = ST_SYNC3;
            end
            ST_SYNC3: begin
                if (i_byte == ZERO_BYTE) n_state = ST_DATA;
                n_byte_pos = '0;
                n_chan_pos = '0;
            end
            ST_DATA: begin
                if (r_chan_pos < CHAN_POS_W'(CHANNELS)) begin
                    if (r_byte_pos < 2'd2) begin
                        n_held     = {r_held[7:0], i_byte};
                        n_byte_pos = r_byte_pos + 2'd1;
                    end else begin
                        emit       = 1'b1;
                        n_byte_pos = '0;
                        n_chan_pos = r_chan_pos + CHAN_POS_W'(1);
                    end
                end
                // return to the hunt once the frame is complete
                if (n_chan_pos >= CHAN_POS_W'(CHANNELS)) n_state = ST_HUNT;
            end
            default: n_state = ST_HUNT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_HUNT;
            r_byte_pos <= '0;
            r_chan_pos <= '0;
            r_held     <= '0;
            r_valid    <= 1'b0;
        end else begin
            if (i_accept) begin
                r_state    <= n_state;
                r_byte_pos <= n_byte_pos;
                r_chan_pos <= n_chan_pos;
                r_held     <= n_held;
            end
            if (i_accept && emit) begin
                r_valid <= 1'b1;
            end else if (i_advance) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && emit) r_sample <= smp;
    end

    assign o_valid  = r_valid;
    assign o_sample = r_sample;

endmodule

`default_nettype wire

@@ sv/efsd_scale.sv @@
// Scaling stage and output register: raw sample times Q8.24 scale, floor shift by 8.
// Depends on efsd_pkg.
`default_nettype none

module efsd_scale
    import efsd_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_advance,
    input  wire t_sample            i_sample,
    input  wire logic [SCALE_W-1:0] i_scale,
    input  wire logic               i_out_ready,
    output logic                    o_valid,
    output logic signed [RAW_W-1:0] o_raw,
    output logic signed [UV_W-1:0]  o_uv,
    output logic [CHAN_IDX_W-1:0]   o_chan,
    output logic                    o_last
);

    logic signed [PROD_W-1:0] prod;
    logic                     r_valid;
    t_sample                  r_sample;
    logic signed [UV_W-1:0]   r_uv;

    // scale is unsigned: widen with a zero sign bit
    assign prod = PROD_W'(i_sample.raw) * $signed({1'b0, i_scale});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_advance) begin
            r_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_sample <= i_sample;
            r_uv     <= prod[FRAC_DROP +: UV_W];
        end
    end

    assign o_valid = r_valid;
    assign o_raw   = r_sample.raw;
    assign o_uv    = r_uv;
    assign o_chan  = r_sample.chan;
    assign o_last  = r_sample.last;

endmodule

`default_nettype wire
